>>> rtl/core/tchc_pkg.sv
// Shared types and constants for the three-channel hysteresis controller.
// Operation codes, register indexes, device bit positions and reset values.
// No dependencies.
`timescale 1ns / 1ps

package tchc_pkg;

	// Request operation carried in s_axis_tuser
	typedef enum logic [1:0] {
		OP_SAMPLE  = 2'd0,
		OP_COMMAND = 2'd1,
		OP_READ    = 2'd2
	} op_t;

	// Configuration register indexes
	localparam logic [2:0] REG_AUTO_MODE  = 3'd0;
	localparam logic [2:0] REG_TEMP_LOW   = 3'd1;
	localparam logic [2:0] REG_TEMP_HIGH  = 3'd2;
	localparam logic [2:0] REG_SOIL_LOW   = 3'd3;
	localparam logic [2:0] REG_SOIL_HIGH  = 3'd4;
	localparam logic [2:0] REG_LIGHT_LOW  = 3'd5;
	localparam logic [2:0] REG_LIGHT_HIGH = 3'd6;

	// Command targets
	localparam logic [1:0] SEL_PUMP = 2'd0;
	localparam logic [1:0] SEL_FAN  = 2'd1;
	localparam logic [1:0] SEL_LAMP = 2'd2;

	// Bit positions in the device and report vectors
	localparam int BIT_PUMP = 0;
	localparam int BIT_FAN  = 1;
	localparam int BIT_LAMP = 2;

	localparam int TEMP_W  = 12;
	localparam int LEVEL_W = 7;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

	// Reset values of the configuration registers
	localparam logic [TEMP_W-1:0]  TEMP_LOW_RST   = 12'd200;
	localparam logic [TEMP_W-1:0]  TEMP_HIGH_RST  = 12'd300;
	localparam logic [LEVEL_W-1:0] SOIL_LOW_RST   = 7'd30;
	localparam logic [LEVEL_W-1:0] SOIL_HIGH_RST  = 7'd80;
	localparam logic [LEVEL_W-1:0] LIGHT_LOW_RST  = 7'd20;
	localparam logic [LEVEL_W-1:0] LIGHT_HIGH_RST = 7'd90;

	// Saturate a percent level to the top of its range
	function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] v);
		return (v > LEVEL_MAX) ? LEVEL_MAX : v;
	endfunction

endpackage

>>> rtl/core/three_channel_hysteresis_controller_core.sv
// Three-channel hysteresis controller: fan, pump and lamp drive with report bits.
// Depends on tchc_pkg for operation codes, register indexes and reset values.
// Path: an accepted request passes through the input register, then the result register,
//   where its result is held until taken.
// Throughput: one request per cycle; input register and result register each stall
//   only when the stage after them is full and not drained in the same cycle.
// Reset: arst_n clears the devices, held temperature, pending reports and valids,
//   and loads the configuration registers with their defaults.
`timescale 1ns / 1ps

module three_channel_hysteresis_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	// Request channel
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: temp_tenths[11:0], temp_valid[12], soil_level[19:13],
	//        light_level[26:20], device_select[28:27], device_on[29], zero[31:30]
	input  logic [31:0] s_axis_tdata,
	// tuser: operation[1:0]
	input  logic [1:0]  s_axis_tuser,
	// Result channel
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: pump_on[0], fan_on[1], lamp_on[2], report_bits[5:3], zero[7:6]
	output logic [7:0]  m_axis_tdata,
	// Configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	// Configuration registers
	logic                            auto_mode_q;
	logic [tchc_pkg::TEMP_W-1:0]     temp_low_q, temp_high_q;
	logic [tchc_pkg::LEVEL_W-1:0]    soil_low_q, soil_high_q;
	logic [tchc_pkg::LEVEL_W-1:0]    light_low_q, light_high_q;

	// Controller state
	logic [2:0]                      dev_q, dev_d;
	logic [2:0]                      pend_q, pend_d;
	logic [tchc_pkg::TEMP_W-1:0]     temp_q, temp_d;

	// Input register
	logic                            valid_s1;
	tchc_pkg::op_t                   op_s1;
	logic [tchc_pkg::TEMP_W-1:0]     temp_s1;
	logic                            temp_valid_s1;
	logic [tchc_pkg::LEVEL_W-1:0]    soil_s1, light_s1;
	logic [1:0]                      sel_s1;
	logic                            dev_on_s1;

	// Result register
	logic                            out_valid_q;
	logic [2:0]                      out_dev_q;
	logic [2:0]                      out_rep_q;

	logic                            advance;
	logic [2:0]                      report;
	logic [tchc_pkg::LEVEL_W-1:0]    soil_sat, light_sat;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_mode_q  <= 1'b0;
			temp_low_q   <= tchc_pkg::TEMP_LOW_RST;
			temp_high_q  <= tchc_pkg::TEMP_HIGH_RST;
			soil_low_q   <= tchc_pkg::SOIL_LOW_RST;
			soil_high_q  <= tchc_pkg::SOIL_HIGH_RST;
			light_low_q  <= tchc_pkg::LIGHT_LOW_RST;
			light_high_q <= tchc_pkg::LIGHT_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tchc_pkg::REG_AUTO_MODE:  auto_mode_q  <= cfg_data[0];
				tchc_pkg::REG_TEMP_LOW:   temp_low_q   <= cfg_data;
				tchc_pkg::REG_TEMP_HIGH:  temp_high_q  <= cfg_data;
				tchc_pkg::REG_SOIL_LOW:   soil_low_q   <= cfg_data[tchc_pkg::LEVEL_W-1:0];
				tchc_pkg::REG_SOIL_HIGH:  soil_high_q  <= cfg_data[tchc_pkg::LEVEL_W-1:0];
				tchc_pkg::REG_LIGHT_LOW:  light_low_q  <= cfg_data[tchc_pkg::LEVEL_W-1:0];
				tchc_pkg::REG_LIGHT_HIGH: light_high_q <= cfg_data[tchc_pkg::LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture the request into the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1         <= tchc_pkg::op_t'(s_axis_tuser);
			temp_s1       <= s_axis_tdata[11:0];
			temp_valid_s1 <= s_axis_tdata[12];
			soil_s1       <= s_axis_tdata[19:13];
			light_s1      <= s_axis_tdata[26:20];
			sel_s1        <= s_axis_tdata[28:27];
			dev_on_s1     <= s_axis_tdata[29];
		end
	end

	assign soil_sat  = tchc_pkg::sat_level(soil_s1);
	assign light_sat = tchc_pkg::sat_level(light_s1);

	// Evaluate the request against the held state
	always_comb begin
		dev_d  = dev_q;
		pend_d = pend_q;
		temp_d = temp_q;
		report = pend_q;
		unique case (op_s1)
			tchc_pkg::OP_SAMPLE: begin
				if (temp_valid_s1) begin
					temp_d = temp_s1;
				end
				if (auto_mode_q) begin
					// on test first, so crossed limits favor on
					if (temp_d > temp_high_q) begin
						dev_d[tchc_pkg::BIT_FAN] = 1'b1;
					end else if (temp_d < temp_low_q) begin
						dev_d[tchc_pkg::BIT_FAN] = 1'b0;
					end
					if (soil_sat < soil_low_q) begin
						dev_d[tchc_pkg::BIT_PUMP] = 1'b1;
					end else if (soil_sat > soil_high_q) begin
						dev_d[tchc_pkg::BIT_PUMP] = 1'b0;
					end
					if (light_sat < light_low_q) begin
						dev_d[tchc_pkg::BIT_LAMP] = 1'b1;
					end else if (light_sat > light_high_q) begin
						dev_d[tchc_pkg::BIT_LAMP] = 1'b0;
					end
				end
				pend_d = pend_q | (dev_d ^ dev_q);
				report = pend_d;
			end
			tchc_pkg::OP_COMMAND: begin
				if (!auto_mode_q) begin
					unique case (sel_s1)
						tchc_pkg::SEL_PUMP: begin
							dev_d[tchc_pkg::BIT_PUMP]  = dev_on_s1;
							pend_d[tchc_pkg::BIT_PUMP] = 1'b1;
						end
						tchc_pkg::SEL_FAN: begin
							dev_d[tchc_pkg::BIT_FAN]  = dev_on_s1;
							pend_d[tchc_pkg::BIT_FAN] = 1'b1;
						end
						tchc_pkg::SEL_LAMP: begin
							dev_d[tchc_pkg::BIT_LAMP]  = dev_on_s1;
							pend_d[tchc_pkg::BIT_LAMP] = 1'b1;
						end
						default: ;
					endcase
				end
				report = pend_d;
			end
			tchc_pkg::OP_READ: begin
				// report the bits, then drop them
				pend_d = 3'b000;
			end
			default: ;
		endcase
	end

	// Advance state when the request moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q  <= 3'b000;
			pend_q <= 3'b000;
			temp_q <= '0;
		end else if (advance) begin
			dev_q  <= dev_d;
			pend_q <= pend_d;
			temp_q <= temp_d;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_dev_q <= dev_d;
			out_rep_q <= report;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_rep_q, out_dev_q};

	// A stalled input register keeps its request
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input register dropped a stalled request");

	// A read request leaves nothing pending
	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == tchc_pkg::OP_READ |=> pend_q == 3'b000)
		else $error("pending reports not cleared by read");

	// In manual mode a sample never switches a device
	a_manual_sample: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == tchc_pkg::OP_SAMPLE && !auto_mode_q |=> $stable(dev_q))
		else $error("device switched by a sample in manual mode");

	// A device change always leaves its report bit pending
	a_change_reported: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 != tchc_pkg::OP_READ |=> ((dev_q ^ $past(dev_q)) & ~pend_q) == 3'b000)
		else $error("device change without pending report");

endmodule
